// ===== hw/rtl/lru_k_frame_replacer_top_assert.svh =====
// assertion macros for the lru-k frame replacer
// used by lru_k_frame_replacer_top; expects i_clk and i_rst_n in scope
`ifndef LRU_K_FRAME_REPLACER_TOP_ASSERT_SVH
`define LRU_K_FRAME_REPLACER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define LKR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lkr same-cycle check failed");

// next-cycle implication, off during reset
`define LKR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lkr next-cycle check failed");

`endif

// ===== hw/rtl/lkr_pkg.sv =====
// shared types, sizes and helpers of the lru-k frame replacer
// no dependencies
`default_nettype none

package lkr_pkg;

    localparam int FRAMES   = 64;
    localparam int K_MAX    = 8;
    localparam int TS_WIDTH = 32;

    localparam int FW    = $clog2(FRAMES);
    localparam int HW    = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int NW    = $clog2(K_MAX + 1);
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int AW    = $clog2(FRAMES * K_MAX);

    localparam logic [1:0] MODE_ACCESS = 2'd0;
    localparam logic [1:0] MODE_UNPIN  = 2'd1;
    localparam logic [1:0] MODE_EVICT  = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] frame;
    } t_in;

    typedef struct packed {
        logic       victim_valid;
        logic [5:0] victim_frame;
        logic [6:0] evictable_count;
    } t_out;

    // per-frame bookkeeping held in one cell
    typedef struct packed {
        logic          known;
        logic          mark;
        logic [NW-1:0] fill;
        logic [HW-1:0] head;
    } t_cell_state;

    typedef struct packed {
        logic shift;
        logic wr;
    } t_cell_ctl;

    // one scanned frame as seen by the picker
    typedef struct packed {
        logic                valid;
        logic                mark;
        logic                inf;
        logic [TS_WIDTH-1:0] old;
        logic [FW-1:0]       frame;
    } t_cand;

    // effective k: zero acts as one, large values clip to K_MAX
    function automatic logic [NW-1:0] eff_k(input logic [3:0] k);
        logic [NW-1:0] r;
        if (k == 4'd0) begin
            r = NW'(1);
        end else if (32'(k) > K_MAX) begin
            r = NW'(K_MAX);
        end else begin
            r = NW'(k);
        end
        return r;
    endfunction

    // ring slot of the j-th most recent entry
    function automatic logic [HW-1:0] ring_slot(input logic [HW-1:0] head,
                                                input logic [NW-1:0] j);
        int t;
        t = int'(head) + K_MAX - int'(j);
        if (t >= K_MAX) begin
            t = t - K_MAX;
        end
        return HW'(t);
    endfunction

    function automatic logic [AW-1:0] hist_addr(input logic [FW-1:0] f,
                                                input logic [HW-1:0] s);
        return AW'(AW'(f) * AW'(K_MAX)) + AW'(s);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lkr_cell.sv =====
// one cell of the frame chain: bookkeeping of a single frame
// depends on lkr_pkg
`default_nettype none

module lkr_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lkr_pkg::t_cell_ctl   i_ctl,
    input  lkr_pkg::t_cell_state i_wr_state,
    input  lkr_pkg::t_cell_state i_nbr,
    output lkr_pkg::t_cell_state o_state
);

    lkr_pkg::t_cell_state r_state;

    // rotate along the chain during a scan, else take a local update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_ctl.shift) begin
            r_state <= i_nbr;
        end else if (i_ctl.wr) begin
            r_state <= i_wr_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// ===== hw/rtl/lkr_pick.sv =====
// victim picker: keeps the best evictable frame seen in a scan
// depends on lkr_pkg
`default_nettype none

module lkr_pick (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_clear,
    input  lkr_pkg::t_cand           i_cand,
    output logic                     o_have,
    output logic [lkr_pkg::FW-1:0]   o_frame
);

    logic                         r_have;
    logic                         r_inf;
    logic [lkr_pkg::TS_WIDTH-1:0] r_old;
    logic [lkr_pkg::FW-1:0]       r_frame;
    logic                         w_win;

    // larger distance means smaller oldest stamp; strict so low index keeps ties
    always_comb begin
        w_win = !r_have || (i_cand.inf && !r_inf) ||
                ((i_cand.inf == r_inf) && (i_cand.old < r_old));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_clear) begin
            r_have <= 1'b0;
        end else if (i_cand.valid && i_cand.mark && w_win) begin
            r_have  <= 1'b1;
            r_inf   <= i_cand.inf;
            r_old   <= i_cand.old;
            r_frame <= i_cand.frame;
        end
    end

    assign o_have  = r_have;
    assign o_frame = r_frame;

endmodule

`default_nettype wire

// ===== hw/rtl/lru_k_frame_replacer_top.sv =====
// lru-k frame replacer: control, history memory, chain of frame cells
// depends on lkr_pkg, lkr_cell, lkr_pick, lru_k_frame_replacer_top_assert.svh
//
// usage
// - input channel i_in_valid / o_in_stall carries a word of mode and frame;
//   mode access pins a frame, unpin makes it evictable, evict asks for a victim
// - output channel o_out_valid / i_out_stall returns one word per input word:
//   victim flag, victim frame and the evictable count after the item
// - config channel i_cfg_valid / o_cfg_ready writes k_depth; write only when idle
// - one item at a time; access, unpin and unknown modes pass through the run
//   and finish states to output; eviction adds a scan rotating every frame
//   cell past the history memory read port, then drain and victim clear;
//   the next word can be taken in the cycle after the output word is loaded
// - an output word waiting on a stalled receiver sits in the output register;
//   the next item is still accepted and worked, and its result waits for that
//   register to empty
// - synchronous reset clears all frame cells, the clock, the count and sets
//   k_depth to 2; no clearing pass is needed
`default_nettype none

module lru_k_frame_replacer_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_stall,
    input  lkr_pkg::t_in i_in_word,
    output logic         o_out_valid,
    input  wire          i_out_stall,
    output lkr_pkg::t_out o_out_word,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire [3:0]    i_cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_VCLR  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]                   r_state;
    logic [3:0]                   r_k;
    logic [1:0]                   r_mode;
    logic [lkr_pkg::FW-1:0]       r_fidx;
    logic                         r_in_range;
    logic [lkr_pkg::TS_WIDTH-1:0] r_clk_ts;
    logic [lkr_pkg::CNT_W-1:0]    r_cnt;
    logic [lkr_pkg::FW-1:0]       r_step;
    logic                         r_vv;
    logic [lkr_pkg::FW-1:0]       r_vf;
    logic                         r_ov;
    lkr_pkg::t_out                r_out;
    logic [lkr_pkg::TS_WIDTH-1:0] r_rd;
    logic                         r_p_valid;
    logic                         r_p_mark;
    logic                         r_p_inf;
    logic                         r_p_zero;
    logic [lkr_pkg::FW-1:0]       r_p_frame;

    logic [lkr_pkg::TS_WIDTH-1:0] r_mem [lkr_pkg::FRAMES*lkr_pkg::K_MAX];

    lkr_pkg::t_cell_state w_cell [lkr_pkg::FRAMES];
    lkr_pkg::t_cell_state w_sel;
    lkr_pkg::t_cell_state w_upd;
    logic                 w_upd_en;
    logic [lkr_pkg::FW-1:0] w_uidx;
    logic                 w_shift;
    logic                 w_have;
    logic [lkr_pkg::FW-1:0] w_vict;
    logic [lkr_pkg::NW-1:0] w_k;
    logic                 w_inf;
    logic [lkr_pkg::NW-1:0] w_j;
    lkr_pkg::t_cand       w_cand;
    logic                 w_out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;
    assign w_shift     = (r_state == ST_SCAN);
    assign w_out_free  = !r_ov || !i_out_stall;
    assign w_k         = lkr_pkg::eff_k(r_k);

    // chain of frame cells, rotating toward cell 0 during a scan
    for (genvar g = 0; g < lkr_pkg::FRAMES; g++) begin : g_cell
        lkr_pkg::t_cell_ctl w_ctl;
        assign w_ctl.shift = w_shift;
        assign w_ctl.wr    = w_upd_en && (w_uidx == lkr_pkg::FW'(g));
        lkr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_wr_state (w_upd),
            .i_nbr      (w_cell[(g + 1) % lkr_pkg::FRAMES]),
            .o_state    (w_cell[g])
        );
    end

    // frame update: access, unpin, or victim clear
    always_comb begin
        w_uidx   = (r_state == ST_VCLR) ? w_vict : r_fidx;
        w_sel    = w_cell[w_uidx];
        w_upd    = w_sel;
        w_upd_en = 1'b0;
        if (r_state == ST_RUN && r_in_range) begin
            if (r_mode == lkr_pkg::MODE_ACCESS) begin
                w_upd.known = 1'b1;
                w_upd.mark  = 1'b0;
                if (32'(w_sel.fill) < lkr_pkg::K_MAX) begin
                    w_upd.fill = w_sel.fill + 1'b1;
                end
                if (32'(w_sel.head) == lkr_pkg::K_MAX - 1) begin
                    w_upd.head = '0;
                end else begin
                    w_upd.head = w_sel.head + 1'b1;
                end
                w_upd_en = 1'b1;
            end else if (r_mode == lkr_pkg::MODE_UNPIN && w_sel.known && !w_sel.mark) begin
                w_upd.mark = 1'b1;
                w_upd_en   = 1'b1;
            end
        end else if (r_state == ST_VCLR && w_have) begin
            w_upd.fill = '0;
            w_upd.head = '0;
            w_upd.mark = 1'b0;
            w_upd_en   = 1'b1;
        end
    end

    // scan lookup on the cell at the head of the chain
    always_comb begin
        w_inf = (w_cell[0].fill < w_k);
        w_j   = w_inf ? w_cell[0].fill : w_k;
    end

    // history memory: write on access, registered read during scan
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && r_in_range && r_mode == lkr_pkg::MODE_ACCESS) begin
            r_mem[lkr_pkg::hist_addr(r_fidx, w_sel.head)] <= r_clk_ts;
        end
        r_rd <= r_mem[lkr_pkg::hist_addr(r_step, lkr_pkg::ring_slot(w_cell[0].head, w_j))];
    end

    // pipeline stage alongside the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= (r_state == ST_SCAN);
        end
        r_p_mark  <= w_cell[0].mark;
        r_p_inf   <= w_inf;
        r_p_zero  <= (w_cell[0].fill == '0);
        r_p_frame <= r_step;
    end

    always_comb begin
        w_cand.valid = r_p_valid;
        w_cand.mark  = r_p_mark;
        w_cand.inf   = r_p_inf;
        w_cand.old   = r_p_zero ? '0 : r_rd;
        w_cand.frame = r_p_frame;
    end

    lkr_pick u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (r_state == ST_RUN),
        .i_cand  (w_cand),
        .o_have  (w_have),
        .o_frame (w_vict)
    );

    // sequencer, clock, count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_k      <= 4'd2;
            r_clk_ts <= '0;
            r_cnt    <= '0;
            r_step   <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_k <= i_cfg_data;
            end
            // a finishing item reloads the output register itself
            if (r_ov && !i_out_stall && r_state != ST_FIN) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_mode     <= i_in_word.mode;
                        r_fidx     <= lkr_pkg::FW'(i_in_word.frame);
                        r_in_range <= (32'(i_in_word.frame) < lkr_pkg::FRAMES);
                        r_state    <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_vv   <= 1'b0;
                    r_vf   <= '0;
                    r_step <= '0;
                    if (r_mode == lkr_pkg::MODE_EVICT) begin
                        r_state <= ST_SCAN;
                    end else begin
                        if (r_in_range && r_mode == lkr_pkg::MODE_ACCESS) begin
                            if (w_sel.mark) begin
                                r_cnt <= r_cnt - 1'b1;
                            end
                            if (r_clk_ts != '1) begin
                                r_clk_ts <= r_clk_ts + 1'b1;
                            end
                        end else if (r_in_range && r_mode == lkr_pkg::MODE_UNPIN &&
                                     w_sel.known && !w_sel.mark) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_state <= ST_FIN;
                    end
                end
                ST_SCAN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == lkr_pkg::FW'(lkr_pkg::FRAMES - 1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_VCLR;
                end
                ST_VCLR: begin
                    if (w_have) begin
                        r_vv  <= 1'b1;
                        r_vf  <= w_vict;
                        r_cnt <= r_cnt - 1'b1;
                    end
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_ov                  <= 1'b1;
                        r_out.victim_valid    <= r_vv;
                        r_out.victim_frame    <= 6'(r_vf);
                        r_out.evictable_count <= 7'(r_cnt);
                        r_state               <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`include "lru_k_frame_replacer_top_assert.svh"

    // count of evictable frames stays within the frame set
    `LKR_ASSERT_IMPL(a_cnt_range, 1'b1, 32'(r_cnt) <= lkr_pkg::FRAMES)
    // a full rotation ends the scan with the cells back home
    `LKR_ASSERT_NEXT(a_scan_end, r_state == ST_SCAN && r_step == lkr_pkg::FW'(lkr_pkg::FRAMES - 1), r_state == ST_DRAIN)
    // a found victim drops the count by one
    `LKR_ASSERT_NEXT(a_vict_cnt, r_state == ST_VCLR && w_have, r_cnt == $past(r_cnt) - 1'b1)

endmodule

`default_nettype wire
